>>> hw/rtl/kes_pkg.sv
package kes_pkg;

  // Sizing
  localparam int unsigned KeysDef  = 4;
  localparam int unsigned PinCount = 4;
  localparam int unsigned FlagW    = 6;
  localparam int unsigned CntW     = 16;
  localparam int unsigned DivW     = 8;

  // Flag bit positions
  localparam int unsigned FlagDown   = 0;
  localparam int unsigned FlagUp     = 1;
  localparam int unsigned FlagSingle = 2;
  localparam int unsigned FlagLong   = 3;
  localparam int unsigned FlagRepeat = 4;
  localparam int unsigned FlagHold   = 5;
  localparam logic [FlagW-1:0] FlagHoldMask = 6'b10_0000;

  // Item opcodes
  localparam logic OpTick  = 1'b0;
  localparam logic OpCheck = 1'b1;

  // Per-key press phase; code 3 is unused and decodes as idle
  localparam logic [1:0] PhaseIdle     = 2'd0;
  localparam logic [1:0] PhaseWaitLong = 2'd1;
  localparam logic [1:0] PhaseRepeat   = 2'd2;

  // Register indexes
  localparam logic [1:0] RegLongTime   = 2'd0;
  localparam logic [1:0] RegRepeatTime = 2'd1;
  localparam logic [1:0] RegScanPeriod = 2'd2;

  localparam logic [CntW-1:0] LongTimeRst   = 16'd1000;
  localparam logic [CntW-1:0] RepeatTimeRst = 16'd200;
  localparam logic [DivW-1:0] ScanPeriodRst = 8'd10;

  typedef struct packed {
    logic [FlagW-1:0] flags;
    logic             cur;
    logic             prev;
    logic [1:0]       phase;
    logic [CntW-1:0]  cnt;
  } key_state_t;

  typedef struct packed {
    logic [CntW-1:0] long_time;
    logic [CntW-1:0] repeat_time;
    logic [DivW-1:0] scan_period;
  } cfg_t;

endpackage

>>> hw/rtl/kes_item_if.sv
interface kes_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] pin_levels;
  logic [1:0] key_index;
  logic [5:0] flag_mask;

  modport source (output valid, op, pin_levels, key_index, flag_mask, input ready);
  modport sink   (input valid, op, pin_levels, key_index, flag_mask, output ready);
endinterface

>>> hw/rtl/kes_result_if.sv
interface kes_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

>>> hw/rtl/kes_cfg_if.sv
interface kes_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/key_event_scanner_core.sv
// Pipeline: the item's key state is read into the read stage at its transfer, and the update
//   is registered into the output register once that register is free or being drained.
// Throughput: 1 item per cycle unless the result output stalls; the state memory is read at the
//   transfer and written back when the update fires, with a write-first bypass on the read.
// Reset: rst_ni async, active low; registers return to 1000 / 200 / 10, all key state
//   reads as zero through per-key valid bits, no clearing pass.
module key_event_scanner_core #(
  parameter int unsigned KEYS = kes_pkg::KeysDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  kes_item_if.sink      item_i,
  kes_result_if.source  result_o,
  kes_cfg_if.sink       cfg_i
);

  kes_pkg::cfg_t       cfg;
  kes_pkg::key_state_t rd_state [KEYS];
  kes_pkg::key_state_t wr_state [KEYS];
  logic [KEYS-1:0]     we;
  logic                hit;

  // Read stage: item held while its state words come out of the memory
  logic       rd_valid_q;
  logic       rd_op_q;
  logic [3:0] rd_pins_q;
  logic [1:0] rd_key_q;
  logic [5:0] rd_mask_q;

  // Output register
  logic out_valid_q;
  logic out_hit_q;

  logic upd_fire;
  logic in_xfer;

  // Update stage fires when the output register is free or being drained
  assign upd_fire    = rd_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !rd_valid_q || upd_fire;
  assign in_xfer     = item_i.valid && item_i.ready;

  kes_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Writes happen only on an update; the read of the next item bypasses them
  kes_state_mem #(
    .KEYS (KEYS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_xfer),
    .we_i    (we & {KEYS{upd_fire}}),
    .wdata_i (wr_state),
    .rdata_o (rd_state)
  );

  kes_update #(
    .KEYS (KEYS)
  ) u_upd (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (upd_fire),
    .op_i         (rd_op_q),
    .pin_levels_i (rd_pins_q),
    .key_index_i  (rd_key_q),
    .flag_mask_i  (rd_mask_q),
    .cfg_i        (cfg),
    .cur_i        (rd_state),
    .nxt_o        (wr_state),
    .we_o         (we),
    .hit_o        (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        rd_valid_q <= item_i.valid;
      end
      if (upd_fire) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_op_q   <= item_i.op;
      rd_pins_q <= item_i.pin_levels;
      rd_key_q  <= item_i.key_index;
      rd_mask_q <= item_i.flag_mask;
    end
    if (upd_fire) begin
      out_hit_q <= hit;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.hit   = out_hit_q;

endmodule

>>> hw/rtl/kes_cfg_regs.sv
module kes_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  kes_cfg_if.sink       cfg_i,
  output kes_pkg::cfg_t cfg_o
);

  kes_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_time   <= kes_pkg::LongTimeRst;
      cfg_q.repeat_time <= kes_pkg::RepeatTimeRst;
      cfg_q.scan_period <= kes_pkg::ScanPeriodRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        kes_pkg::RegLongTime:   cfg_q.long_time   <= cfg_i.data;
        kes_pkg::RegRepeatTime: cfg_q.repeat_time <= cfg_i.data;
        kes_pkg::RegScanPeriod: cfg_q.scan_period <= cfg_i.data[kes_pkg::DivW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/kes_state_mem.sv
module kes_state_mem #(
  parameter int unsigned KEYS = kes_pkg::KeysDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [KEYS-1:0]     we_i,
  input  kes_pkg::key_state_t wdata_i [KEYS],
  output kes_pkg::key_state_t rdata_o [KEYS]
);

  kes_pkg::key_state_t mem_q [KEYS];
  kes_pkg::key_state_t rd_q  [KEYS];
  logic [KEYS-1:0]     valid_q;

  // Entry not yet written reads as the all-zero reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_q | we_i;
    end
  end

  // Read data takes the word being written in the same cycle (write-first bypass)
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < KEYS; k++) begin
      if (we_i[k]) begin
        mem_q[k] <= wdata_i[k];
      end
      if (rd_en_i) begin
        if (we_i[k]) begin
          rd_q[k] <= wdata_i[k];
        end else if (valid_q[k]) begin
          rd_q[k] <= mem_q[k];
        end else begin
          rd_q[k] <= '0;
        end
      end
    end
  end

  assign rdata_o = rd_q;

endmodule

>>> hw/rtl/kes_update.sv
module kes_update #(
  parameter int unsigned KEYS = kes_pkg::KeysDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                op_i,
  input  logic [3:0]          pin_levels_i,
  input  logic [1:0]          key_index_i,
  input  logic [5:0]          flag_mask_i,
  input  kes_pkg::cfg_t       cfg_i,
  input  kes_pkg::key_state_t cur_i [KEYS],
  output kes_pkg::key_state_t nxt_o [KEYS],
  output logic [KEYS-1:0]     we_o,
  output logic                hit_o
);

  logic [kes_pkg::DivW-1:0] div_q;
  logic [kes_pkg::DivW-1:0] div_inc;
  logic                     sample;

  assign div_inc = div_q + kes_pkg::DivW'(1);
  assign sample  = (div_inc >= cfg_i.scan_period);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else if (fire_i && (op_i == kes_pkg::OpTick)) begin
      div_q <= sample ? '0 : div_inc;
    end
  end

  always_comb begin
    kes_pkg::key_state_t      st;
    kes_pkg::key_state_t      nx;
    logic [kes_pkg::FlagW-1:0] f;
    logic                     pressed;
    hit_o = 1'b0;
    for (int k = 0; k < KEYS; k++) begin
      st      = cur_i[k];
      nx      = st;
      f       = st.flags;
      pressed = 1'b0;
      we_o[k] = 1'b0;
      if (op_i == kes_pkg::OpTick) begin
        we_o[k] = 1'b1;
        if (st.cnt != '0) begin
          nx.cnt = st.cnt - kes_pkg::CntW'(1);
        end
        if (sample) begin
          if (k < kes_pkg::PinCount) begin
            pressed = ~pin_levels_i[k % kes_pkg::PinCount];
          end
          nx.prev = st.cur;
          nx.cur  = pressed;
          f[kes_pkg::FlagHold] = pressed;
          if (pressed && !st.cur) begin
            f[kes_pkg::FlagDown] = 1'b1;
          end
          if (!pressed && st.cur) begin
            f[kes_pkg::FlagUp] = 1'b1;
          end
          case (st.phase)
            kes_pkg::PhaseWaitLong: begin
              if (!pressed) begin
                f[kes_pkg::FlagSingle] = 1'b1;
                nx.phase = kes_pkg::PhaseIdle;
              end else if (nx.cnt == '0) begin
                f[kes_pkg::FlagLong] = 1'b1;
                nx.cnt   = cfg_i.repeat_time;
                nx.phase = kes_pkg::PhaseRepeat;
              end
            end
            kes_pkg::PhaseRepeat: begin
              if (!pressed) begin
                nx.phase = kes_pkg::PhaseIdle;
              end else if (nx.cnt == '0) begin
                f[kes_pkg::FlagRepeat] = 1'b1;
                nx.cnt = cfg_i.repeat_time;
              end
            end
            default: begin
              nx.phase = kes_pkg::PhaseIdle;
              if (pressed) begin
                nx.cnt   = cfg_i.long_time;
                nx.phase = kes_pkg::PhaseWaitLong;
              end
            end
          endcase
          nx.flags = f;
        end
      end else if (32'(key_index_i) == k) begin
        if ((st.flags & flag_mask_i) != '0) begin
          hit_o = 1'b1;
          if (flag_mask_i != kes_pkg::FlagHoldMask) begin
            nx.flags = st.flags & ~flag_mask_i;
            we_o[k]  = 1'b1;
          end
        end
      end
      nxt_o[k] = nx;
    end
  end

endmodule
